/* rtl/core/r12u_pkg.sv */
// ----------------------------------------------------------------------------
// r12u_pkg
// Shared types and constants for the packed raw12 unpacker with RGGB split.
// ----------------------------------------------------------------------------
`default_nettype none

package r12u_pkg;

	localparam int BYTE_W  = 8;
	localparam int PIX_W   = 12;
	localparam int CHAN_W  = 2;
	localparam int INDEX_W = 24;
	localparam int REG_W   = 14;
	localparam int CFG_IDX_W = 2;
	// Effective dimension width: holds any clamped width or height up to 65536.
	localparam int DIM_W   = 17;

	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [REG_W-1:0] LINE_WIDTH_RST   = 14'd1920;
	localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 14'd1080;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	// Position tag of one pixel.
	typedef struct packed {
		logic [CHAN_W-1:0]  bayer_channel;
		logic [INDEX_W-1:0] plane_index;
		logic               frame_end;
	} pos_t;

	// One finished result item.
	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		pos_t             pos;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/r12u_byte_if.sv */
// ----------------------------------------------------------------------------
// r12u_byte_if
// Valid/ready channel carrying one packed raw byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface r12u_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;

	modport source (output valid, output raw_byte, input ready);
	modport sink   (input valid, input raw_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/r12u_pix_if.sv */
// ----------------------------------------------------------------------------
// r12u_pix_if
// Valid/ready channel carrying one unpacked pixel with its Bayer tag per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface r12u_pix_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_value;
	logic [1:0]  bayer_channel;
	logic [23:0] plane_index;
	logic        frame_end;

	modport source (output valid, output pixel_value, output bayer_channel,
		output plane_index, output frame_end, input ready);
	modport sink   (input valid, input pixel_value, input bayer_channel,
		input plane_index, input frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/core/r12u_unpack.sv */
// ----------------------------------------------------------------------------
// r12u_unpack
// Three-byte group sequencer: assembles two 12-bit pixels per group.
// ----------------------------------------------------------------------------
`default_nettype none

module r12u_unpack (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [r12u_pkg::BYTE_W-1:0]   raw_byte,
	output logic                               pix_valid,
	output logic [r12u_pkg::PIX_W-1:0]         pixel
);
	import r12u_pkg::*;

	phase_t             phase_q;
	phase_t             phase_next;
	logic [BYTE_W-1:0]  held_q;

	always_comb begin
		case (phase_q)
			PH_FIRST:  phase_next = PH_SECOND;
			PH_SECOND: phase_next = PH_THIRD;
			PH_THIRD:  phase_next = PH_FIRST;
			default:   phase_next = PH_FIRST;
		endcase
	end

	always_comb begin
		case (phase_q)
			PH_FIRST: begin
				pix_valid = 1'b0;
				pixel     = '0;
			end
			PH_SECOND: begin
				pix_valid = 1'b1;
				pixel     = {held_q, raw_byte[7:4]};
			end
			PH_THIRD: begin
				pix_valid = 1'b1;
				pixel     = {held_q[3:0] & NIBBLE_MASK, raw_byte};
			end
			default: begin
				pix_valid = 1'b0;
				pixel     = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			held_q  <= '0;
		end else if (step) begin
			phase_q <= phase_next;
			// keep the byte: the third byte is never needed later
			if (phase_q != PH_THIRD) begin
				held_q <= raw_byte;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/r12u_track.sv */
// ----------------------------------------------------------------------------
// r12u_track
// Column/row tracker: Bayer tag, plane index and end of frame per pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module r12u_track #(
	parameter int MAX_WIDTH  = 8192,
	parameter int MAX_HEIGHT = 8192
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire logic [r12u_pkg::DIM_W-1:0]   eff_width,
	input  wire logic [r12u_pkg::DIM_W-1:0]   eff_height,
	output r12u_pkg::pos_t                    pos
);
	import r12u_pkg::*;

	localparam int CW = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
	localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int XW = DIM_W + 1;

	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [INDEX_W-1:0] red_pairs_q;
	logic [INDEX_W-1:0] blue_pairs_q;
	logic               odd_col;
	logic               odd_row;
	logic               last_col;
	logic               last_row;
	logic               fend;

	assign odd_col  = col_q[0];
	assign odd_row  = row_q[0];
	assign last_col = (XW'(col_q) + XW'(1)) >= XW'(eff_width);
	assign last_row = (XW'(row_q) + XW'(1)) >= XW'(eff_height);
	assign fend     = last_col && last_row;

	assign pos.bayer_channel = {odd_row, odd_col};
	assign pos.plane_index   = odd_row ? blue_pairs_q : red_pairs_q;
	assign pos.frame_end     = fend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			red_pairs_q  <= '0;
			blue_pairs_q <= '0;
		end else if (advance) begin
			if (fend) begin
				col_q        <= '0;
				row_q        <= '0;
				red_pairs_q  <= '0;
				blue_pairs_q <= '0;
			end else begin
				if (odd_col && odd_row) begin
					blue_pairs_q <= blue_pairs_q + 1'b1;
				end
				if (odd_col && !odd_row) begin
					red_pairs_q <= red_pairs_q + 1'b1;
				end
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/raw12_unpack_bayer_split.sv */
// ----------------------------------------------------------------------------
// raw12_unpack_bayer_split
// Packed 12-bit raw unpacker that tags each pixel with its RGGB plane.
// ----------------------------------------------------------------------------
//
//   channel        dir   handshake      payload
//   raw_stream     in    valid/ready    raw_byte[7:0]
//   pixel_stream   out   valid/ready    pixel_value[11:0], bayer_channel[1:0],
//                                       plane_index[23:0], frame_end
//   cfg            in    cfg_we         cfg_index[1:0], cfg_data[13:0]
//
// One byte is taken per cycle while the input is not stalled; every three
// bytes give two pixels. The pixel completed by an accepted byte is in
// the output register in the cycle after the byte is taken. The input
// stalls only when the output register holds a pixel the sink does not
// take. Reset clears the byte phase, all counters and the output valid,
// and loads width 1920 and height 1080.
// ----------------------------------------------------------------------------
`default_nettype none

module raw12_unpack_bayer_split #(
	parameter int MAX_WIDTH  = 8192,
	parameter int MAX_HEIGHT = 8192
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	r12u_byte_if.sink                              raw_stream,
	r12u_pix_if.source                             pixel_stream,
	input  wire logic                              cfg_we,
	input  wire logic [r12u_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [r12u_pkg::REG_W-1:0]        cfg_data
);
	import r12u_pkg::*;

	localparam logic [DIM_W-1:0] MaxW = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MaxH = DIM_W'(MAX_HEIGHT);

	logic [REG_W-1:0]  line_width_q;
	logic [REG_W-1:0]  frame_height_q;
	logic [DIM_W-1:0]  width_clamp;
	logic [DIM_W-1:0]  eff_width;
	logic [DIM_W-1:0]  eff_height;

	logic              accept;
	logic              pix_valid;
	logic [PIX_W-1:0]  pixel;
	pos_t              pos;

	logic              out_valid_q;
	result_t           res_q;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINE_WIDTH:   line_width_q   <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp width into 2..MAX_WIDTH, then force it even.
	always_comb begin
		width_clamp = DIM_W'(line_width_q);
		if (width_clamp < DIM_W'(2)) begin
			width_clamp = DIM_W'(2);
		end
		if (width_clamp > MaxW) begin
			width_clamp = MaxW;
		end
		eff_width = {width_clamp[DIM_W-1:1], 1'b0};
	end

	// Clamp height into 2..MAX_HEIGHT.
	always_comb begin
		eff_height = DIM_W'(frame_height_q);
		if (eff_height < DIM_W'(2)) begin
			eff_height = DIM_W'(2);
		end
		if (eff_height > MaxH) begin
			eff_height = MaxH;
		end
	end

	// Take a byte whenever the output register is empty or being drained.
	assign raw_stream.ready = !out_valid_q || pixel_stream.ready;
	assign accept           = raw_stream.valid && raw_stream.ready;

	r12u_unpack u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.raw_byte  (raw_stream.raw_byte),
		.pix_valid (pix_valid),
		.pixel     (pixel)
	);

	// Advance the position only on bytes that complete a pixel.
	r12u_track #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (accept && pix_valid),
		.eff_width  (eff_width),
		.eff_height (eff_height),
		.pos        (pos)
	);

	// Output register: load a new pixel, hold on stall, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && pix_valid) begin
			out_valid_q <= 1'b1;
		end else if (pixel_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pix_valid) begin
			res_q.pixel_value <= pixel;
			res_q.pos         <= pos;
		end
	end

	assign pixel_stream.valid         = out_valid_q;
	assign pixel_stream.pixel_value   = res_q.pixel_value;
	assign pixel_stream.bayer_channel = res_q.pos.bayer_channel;
	assign pixel_stream.plane_index   = res_q.pos.plane_index;
	assign pixel_stream.frame_end     = res_q.pos.frame_end;

endmodule

`default_nettype wire

/* dv/raw12_unpack_bayer_split_tb.sv */
// ----------------------------------------------------------------------------
// raw12_unpack_bayer_split_tb
// Self-checking bench for the packed raw12 unpacker with RGGB plane split.
// A byte stream is driven through the valid/ready input with random gaps.
// Each accepted byte is fed to a software unpacker that tracks the byte
// phase, column, row and plane counters under the current frame size, and
// queues the pixel it expects. Pixels leaving the block are compared field
// by field in order. Frame size is changed between bursts, with clamped,
// odd and full-range values and a row shrink in the middle of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module raw12_unpack_bayer_split_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import r12u_pkg::*;

	localparam int MAX_W         = 8192;
	localparam int MAX_H         = 8192;
	localparam int ITEM_TARGET   = 1000;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 400;
	localparam int MAX_REPORTS   = 10;

	// Indexes that map to no register; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// ------------------------------------------------------------------------
	// Expected-pixel tracker: software unpacker plus the queue of pixels owed.
	// ------------------------------------------------------------------------
	class unpack_scoreboard;
		result_t            pixels_due[$];
		logic [REG_W-1:0]   width_reg;
		logic [REG_W-1:0]   height_reg;
		phase_t             byte_phase;
		logic [BYTE_W-1:0]  held_byte;
		int unsigned        col;
		int unsigned        row;
		logic [INDEX_W-1:0] red_pairs;
		logic [INDEX_W-1:0] blue_pairs;
		int                 mismatches;

		function new();
			width_reg  = LINE_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			byte_phase = PH_FIRST;
			held_byte  = '0;
			col        = 0;
			row        = 0;
			red_pairs  = '0;
			blue_pairs = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
			case (idx)
				CFG_LINE_WIDTH:   width_reg  = data;
				CFG_FRAME_HEIGHT: height_reg = data;
				default: ;
			endcase
		endfunction

		function void unpack_byte(logic [BYTE_W-1:0] b);
			result_t     px;
			int unsigned w;
			int unsigned h;
			logic        odd_col;
			logic        odd_row;
			logic        last_col;
			logic        last_row;
			case (byte_phase)
				PH_FIRST: begin
					held_byte  = b;
					byte_phase = PH_SECOND;
					return;
				end
				PH_SECOND: begin
					px.pixel_value = {held_byte, b[7:4]};
					held_byte      = b;
					byte_phase     = PH_THIRD;
				end
				default: begin
					px.pixel_value = {held_byte[3:0] & NIBBLE_MASK, b};
					byte_phase     = PH_FIRST;
				end
			endcase

			// Clamp the frame size in use; width is also forced even.
			w = width_reg;
			if (w < 2) w = 2;
			if (w > MAX_W) w = MAX_W;
			w = w & ~32'd1;
			h = height_reg;
			if (h < 2) h = 2;
			if (h > MAX_H) h = MAX_H;

			odd_col  = col[0];
			odd_row  = row[0];
			last_col = (col + 1) >= w;
			last_row = (row + 1) >= h;
			px.pos.bayer_channel = {odd_row, odd_col};
			px.pos.plane_index   = odd_row ? blue_pairs : red_pairs;
			px.pos.frame_end     = last_col && last_row;
			pixels_due.push_back(px);

			if (odd_col) begin
				if (odd_row) blue_pairs = blue_pairs + 1'b1;
				else red_pairs = red_pairs + 1'b1;
			end
			if (last_col && last_row) begin
				col        = 0;
				row        = 0;
				red_pairs  = '0;
				blue_pairs = '0;
			end else if (last_col) begin
				col = 0;
				row = row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		function void check_pixel(result_t got);
			result_t want;
			if (pixels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] unexpected pixel: pix %03h ch %0d idx %0d end %0b",
						$realtime, got.pixel_value, got.pos.bayer_channel,
						got.pos.plane_index, got.pos.frame_end);
				return;
			end
			want = pixels_due.pop_front();
			if (got.pixel_value !== want.pixel_value
					|| got.pos.bayer_channel !== want.pos.bayer_channel
					|| got.pos.plane_index !== want.pos.plane_index
					|| got.pos.frame_end !== want.pos.frame_end) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("[%0t] pixel mismatch: exp pix %03h ch %0d idx %0d end %0b",
						$realtime, want.pixel_value, want.pos.bayer_channel,
						want.pos.plane_index, want.pos.frame_end);
					$display("[%0t]                 got pix %03h ch %0d idx %0d end %0b",
						$realtime, got.pixel_value, got.pos.bayer_channel,
						got.pos.plane_index, got.pos.frame_end);
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, interfaces, block
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	r12u_byte_if raw_if();
	r12u_pix_if  pix_if();

	raw12_unpack_bayer_split #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.raw_stream  (raw_if),
		.pixel_stream(pix_if),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	unpack_scoreboard sb = new();

	// Idle odds in percent for each side; zero gives a gap-free stretch.
	int tx_idle_pct = 32;
	int rx_idle_pct = 32;
	// Long sink hold-off, posted by the stimulus and counted by the sink.
	int hold_req    = 0;
	int bytes_sent  = 0;

	// ------------------------------------------------------------------------
	// Stimulus tasks. All of them are entered right after a rising edge.
	// ------------------------------------------------------------------------

	// Offer one byte, with random idle cycles ahead of it, and hold it until
	// the block takes it. Valid stays high into the next item unless it idles.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			raw_if.valid <= 1'b0;
			@(posedge clk);
		end
		raw_if.valid    <= 1'b1;
		raw_if.raw_byte <= b;
		do @(posedge clk); while (!raw_if.ready);
		sb.unpack_byte(b);
		bytes_sent++;
	endtask

	task automatic send_random(input int n);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	// Write one register; the caller drops the write enable after its last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic set_frame(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
		write_reg(CFG_LINE_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	// Stop offering bytes and wait for every owed pixel. A byte that starts a
	// group makes no pixel, so let the block settle before touching config.
	task automatic drain();
		raw_if.valid <= 1'b0;
		while (sb.pixels_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [BYTE_W-1:0] directed_bytes[$];
		logic [REG_W-1:0]  w;
		logic [REG_W-1:0]  h;
		int                n;
		int                k;

		arst_n          = 1'b0;
		raw_if.valid    = 1'b0;
		raw_if.raw_byte = '0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_LINE_WIDTH;
		cfg_data        = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes and mixed nibbles at the reset frame size: all-zero and
		// all-one groups, alternating patterns, nibbles that cross the split.
		directed_bytes = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
			8'hA5, 8'h5A, 8'hC3, 8'h0F, 8'hF0, 8'h81,
			8'h12, 8'h34, 8'h56, 8'h80, 8'h01, 8'h7E};
		foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
		drain();

		// Writes to unmapped indexes must leave the frame size alone; then the
		// smallest sizes, clamped up from zero and one, so frames end quickly.
		write_reg(CFG_SPARE_A, 14'h3FFF);
		write_reg(CFG_SPARE_B, 14'h2AAA);
		set_frame(14'd0, 14'd0);
		send_random(24);
		drain();
		set_frame(14'd1, 14'd1);
		send_random(30);
		drain();

		// Odd width rounds down to even.
		set_frame(14'd3, 14'd3);
		send_random(60);
		drain();

		// Oversized values clamp to the maximum; then the exact maximum.
		set_frame(14'h3FFF, 14'h3FFF);
		send_random(60);
		drain();
		set_frame(14'(MAX_W), 14'(MAX_H));
		send_random(30);
		drain();

		// Shrink the row while the column is already past the new width: the
		// row must end on the next pixel.
		set_frame(14'd4, 14'd2);
		send_random(90);
		drain();

		// Random bursts: mostly tiny frames so frame ends are frequent, now and
		// then a full-range size. One burst runs gap-free on both sides, one
		// runs into a long sink hold-off so the input backs up.
		k = 0;
		while (bytes_sent < ITEM_TARGET) begin
			w = ($urandom_range(9) == 0) ? 14'($urandom_range(0, 16383))
				: 14'($urandom_range(0, 14));
			h = ($urandom_range(9) == 0) ? 14'($urandom_range(0, 16383))
				: 14'($urandom_range(0, 6));
			n = $urandom_range(30, 120);
			tx_idle_pct = (k == 2) ? 0 : 32;
			rx_idle_pct = (k == 2) ? 0 : 32;
			if (k == 2) n = 200;
			set_frame(w, h);
			if (k == 4) hold_req = HOLD_CYCLES;
			send_random(n);
			drain();
			k++;
		end

		if (sb.mismatches == 0 && sb.pixels_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Pixel sink: check every taken pixel, then pick ready for the next edge.
	// ------------------------------------------------------------------------
	initial begin
		result_t got;
		int      hold_left;

		hold_left    = 0;
		pix_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (pix_if.valid && pix_if.ready) begin
				got.pixel_value       = pix_if.pixel_value;
				got.pos.bayer_channel = pix_if.bayer_channel;
				got.pos.plane_index   = pix_if.plane_index;
				got.pos.frame_end     = pix_if.frame_end;
				sb.check_pixel(got);
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_if.ready <= 1'b0;
			end else begin
				pix_if.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: give up when neither side moves an item for too long.
	// ------------------------------------------------------------------------
	initial begin
		int stall_cycles;

		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((raw_if.valid && raw_if.ready) || (pix_if.valid && pix_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
